// ----- design/job_table_engine_unit_assert.svh -----
`ifndef JOB_TABLE_ENGINE_UNIT_ASSERT_SVH
`define JOB_TABLE_ENGINE_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define JTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define JTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/jte_pkg.sv -----
package jte_pkg;

    localparam int JOB_W    = 17;
    localparam int STATE_W  = 2;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_JOB_ID_DEF    = 65536;
    localparam int PID_BITS_DEF      = 22;

    localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL_PID  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND_PID = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND_JOB = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SET_JOB  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SET_PID  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_FIND_FG  = 3'd6;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd3;

    localparam logic [STATE_W-1:0] JOB_ST_FG = 2'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [JOB_W-1:0]    job;
        logic [STATE_W-1:0]  new_state;
    } req_info_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [JOB_W-1:0]    job;
        logic [STATE_W-1:0]  job_state;
    } res_info_t;

endpackage

// ----- design/job_table_engine_unit.sv -----
// Job table: TABLE_ENTRIES slots of {process id, job number, run state} in one
// synchronous RAM, empty after reset. Requests are taken one at a time; each
// request gives exactly one result. A request with a bad id or unused action
// skips the sweep and goes straight to its result; every other request sweeps
// the whole RAM once, one entry per cycle through its single read port, before
// the result is loaded into the output register. The write-back to the matched
// slot happens as the result is loaded. A finished result waits in the output
// register while the next request is already accepted and searched.
module job_table_engine_unit #(
    parameter int TABLE_ENTRIES = jte_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_JOB_ID    = jte_pkg::MAX_JOB_ID_DEF,
    parameter int PID_BITS      = jte_pkg::PID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [jte_pkg::ACTION_W-1:0]      s_action,
    input  logic [PID_BITS-1:0]               s_pid_value,
    input  logic [jte_pkg::JOB_W-1:0]         s_job_number,
    input  logic [jte_pkg::STATE_W-1:0]       s_new_state,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [jte_pkg::STATUS_W-1:0]      m_status,
    output logic [PID_BITS-1:0]               m_pid_out,
    output logic [jte_pkg::JOB_W-1:0]         m_job_out,
    output logic [jte_pkg::STATE_W-1:0]       m_state_out
);

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = PID_BITS + jte_pkg::JOB_W + jte_pkg::STATE_W;

    jte_pkg::req_info_t  req_info;
    jte_pkg::res_info_t  res_info;
    logic [PID_BITS-1:0] res_pid;
    logic                res_valid;
    logic                res_ready;

    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [WORD_W-1:0]   mem_rd_word;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [WORD_W-1:0]   mem_wr_word;

    logic                          m_valid_reg, m_valid_next;
    jte_pkg::res_info_t            out_info_reg;
    logic [PID_BITS-1:0]           out_pid_reg;

    assign req_info.action    = s_action;
    assign req_info.job       = s_job_number;
    assign req_info.new_state = s_new_state;

    jte_table_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WORD_W        (WORD_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_word (mem_rd_word),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_word (mem_wr_word)
    );

    jte_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_JOB_ID    (MAX_JOB_ID),
        .PID_BITS      (PID_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req_info    (req_info),
        .req_pid     (s_pid_value),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_word (mem_rd_word),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_word (mem_wr_word),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_info    (res_info),
        .res_pid     (res_pid)
    );

    // Output register: load when empty or being drained this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_info_reg <= res_info;
            out_pid_reg  <= res_pid;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = out_info_reg.status;
    assign m_pid_out   = out_pid_reg;
    assign m_job_out   = out_info_reg.job;
    assign m_state_out = out_info_reg.job_state;

endmodule

// ----- design/jte_table_mem.sv -----
module jte_table_mem #(
    parameter int TABLE_ENTRIES = jte_pkg::TABLE_ENTRIES_DEF,
    parameter int WORD_W        = jte_pkg::PID_BITS_DEF + jte_pkg::JOB_W + jte_pkg::STATE_W,
    localparam int AW           = $clog2(TABLE_ENTRIES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_word,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_word
);

    logic [WORD_W-1:0]        mem [TABLE_ENTRIES];
    logic [WORD_W-1:0]        q_reg;
    logic [TABLE_ENTRIES-1:0] vld_reg;
    logic                     vq_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as all zero (free slot).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            vq_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                vq_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_word = vq_reg ? q_reg : '0;

endmodule

// ----- design/jte_ctrl.sv -----
module jte_ctrl #(
    parameter int TABLE_ENTRIES = jte_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_JOB_ID    = jte_pkg::MAX_JOB_ID_DEF,
    parameter int PID_BITS      = jte_pkg::PID_BITS_DEF,
    localparam int AW           = $clog2(TABLE_ENTRIES),
    localparam int WORD_W       = PID_BITS + jte_pkg::JOB_W + jte_pkg::STATE_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  jte_pkg::req_info_t  req_info,
    input  logic [PID_BITS-1:0] req_pid,
    output logic                mem_rd_en,
    output logic [AW-1:0]       mem_rd_addr,
    input  logic [WORD_W-1:0]   mem_rd_word,
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output logic [WORD_W-1:0]   mem_wr_word,
    output logic                res_valid,
    input  logic                res_ready,
    output jte_pkg::res_info_t  res_info,
    output logic [PID_BITS-1:0] res_pid
);

    localparam int JOB_W   = jte_pkg::JOB_W;
    localparam int STATE_W = jte_pkg::STATE_W;

    localparam logic [1:0] FSM_IDLE   = 2'd0;
    localparam logic [1:0] FSM_SCAN   = 2'd1;
    localparam logic [1:0] FSM_FINISH = 2'd2;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(TABLE_ENTRIES - 1);
    localparam logic [JOB_W-1:0] MAX_JOB   = JOB_W'(MAX_JOB_ID);
    localparam logic [JOB_W-1:0] JOB_ONE   = JOB_W'(1);

    logic [1:0]                     fsm_reg, fsm_next;
    logic [jte_pkg::ACTION_W-1:0]   act_reg, act_next;
    logic [PID_BITS-1:0]            pid_reg, pid_next;
    logic [JOB_W-1:0]               job_reg, job_next;
    logic [STATE_W-1:0]             nst_reg, nst_next;
    logic                           inval_reg, inval_next;
    logic [AW-1:0]                  rd_addr_reg, rd_addr_next;
    logic                           rd_busy_reg, rd_busy_next;
    logic                           dv_reg;
    logic [AW-1:0]                  didx_reg;
    logic                           found_reg, found_next;
    logic [AW-1:0]                  slot_reg, slot_next;
    logic [WORD_W-1:0]              cap_reg, cap_next;
    logic [JOB_W-1:0]               max_reg, max_next;
    logic [JOB_W-1:0]               next_job_reg, next_job_next;

    logic [PID_BITS-1:0] e_pid, cap_pid;
    logic [JOB_W-1:0]    e_job, cap_job;
    logic [STATE_W-1:0]  e_st;
    logic                hit;
    logic                bad_req;
    logic                done_ok;
    logic [JOB_W-1:0]    job_inc, max_inc;
    logic [WORD_W-1:0]   res_word;

    assign e_pid   = mem_rd_word[WORD_W-1 -: PID_BITS];
    assign e_job   = mem_rd_word[STATE_W +: JOB_W];
    assign e_st    = mem_rd_word[STATE_W-1:0];
    assign cap_pid = cap_reg[WORD_W-1 -: PID_BITS];
    assign cap_job = cap_reg[STATE_W +: JOB_W];

    assign job_inc = (next_job_reg + JOB_ONE > MAX_JOB) ? JOB_ONE : next_job_reg + JOB_ONE;
    assign max_inc = (max_reg + JOB_ONE > MAX_JOB) ? JOB_ONE : max_reg + JOB_ONE;

    always_comb begin
        case (act_reg)
            jte_pkg::ACT_ADD:      hit = (e_pid == '0);
            jte_pkg::ACT_DEL_PID,
            jte_pkg::ACT_FIND_PID,
            jte_pkg::ACT_SET_PID:  hit = (e_pid == pid_reg);
            jte_pkg::ACT_FIND_JOB,
            jte_pkg::ACT_SET_JOB:  hit = (e_job == job_reg);
            jte_pkg::ACT_FIND_FG:  hit = (e_st == jte_pkg::JOB_ST_FG);
            default:               hit = 1'b0;
        endcase
    end

    always_comb begin
        case (req_info.action)
            jte_pkg::ACT_ADD,
            jte_pkg::ACT_DEL_PID,
            jte_pkg::ACT_FIND_PID,
            jte_pkg::ACT_SET_PID:  bad_req = (req_pid == '0);
            jte_pkg::ACT_FIND_JOB,
            jte_pkg::ACT_SET_JOB:  bad_req = (req_info.job == '0);
            jte_pkg::ACT_FIND_FG:  bad_req = 1'b0;
            default:               bad_req = 1'b1;
        endcase
    end

    assign done_ok = !inval_reg && found_reg;

    // Result word and write-back for the matched slot.
    always_comb begin
        res_word    = cap_reg;
        mem_wr_word = cap_reg;
        case (act_reg)
            jte_pkg::ACT_ADD: begin
                res_word    = {pid_reg, next_job_reg, nst_reg};
                mem_wr_word = {pid_reg, next_job_reg, nst_reg};
            end
            jte_pkg::ACT_DEL_PID: begin
                mem_wr_word = '0;
            end
            jte_pkg::ACT_SET_JOB,
            jte_pkg::ACT_SET_PID: begin
                res_word    = {cap_pid, cap_job, nst_reg};
                mem_wr_word = {cap_pid, cap_job, nst_reg};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        fsm_next      = fsm_reg;
        act_next      = act_reg;
        pid_next      = pid_reg;
        job_next      = job_reg;
        nst_next      = nst_reg;
        inval_next    = inval_reg;
        rd_addr_next  = rd_addr_reg;
        rd_busy_next  = rd_busy_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        cap_next      = cap_reg;
        max_next      = max_reg;
        next_job_next = next_job_reg;
        req_ready     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_wr_en     = 1'b0;
        res_valid     = 1'b0;

        case (fsm_reg)
            FSM_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    act_next     = req_info.action;
                    pid_next     = req_pid;
                    job_next     = req_info.job;
                    nst_next     = req_info.new_state;
                    inval_next   = bad_req;
                    found_next   = 1'b0;
                    cap_next     = '0;
                    max_next     = '0;
                    rd_addr_next = '0;
                    rd_busy_next = !bad_req;
                    fsm_next     = bad_req ? FSM_FINISH : FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (rd_busy_reg) begin
                    mem_rd_en = 1'b1;
                    if (rd_addr_reg == LAST_ADDR) begin
                        rd_busy_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                end
                if (dv_reg) begin
                    // Lowest matching slot wins; the rest feed the largest job number.
                    if (hit && !found_reg) begin
                        found_next = 1'b1;
                        slot_next  = didx_reg;
                        cap_next   = mem_rd_word;
                    end else if (e_job > max_reg) begin
                        max_next = e_job;
                    end
                    if (didx_reg == LAST_ADDR) begin
                        fsm_next = FSM_FINISH;
                    end
                end
            end
            FSM_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    fsm_next = FSM_IDLE;
                    if (done_ok) begin
                        case (act_reg)
                            jte_pkg::ACT_ADD: begin
                                mem_wr_en     = 1'b1;
                                next_job_next = job_inc;
                            end
                            jte_pkg::ACT_DEL_PID: begin
                                mem_wr_en     = 1'b1;
                                next_job_next = max_inc;
                            end
                            jte_pkg::ACT_SET_JOB,
                            jte_pkg::ACT_SET_PID: begin
                                mem_wr_en = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    assign mem_rd_addr = rd_addr_reg;
    assign mem_wr_addr = slot_reg;

    always_comb begin
        if (inval_reg) begin
            res_info.status = jte_pkg::STS_INVALID;
        end else if (!found_reg) begin
            res_info.status = (act_reg == jte_pkg::ACT_ADD) ? jte_pkg::STS_FULL
                                                             : jte_pkg::STS_NOT_FOUND;
        end else begin
            res_info.status = jte_pkg::STS_OK;
        end
        res_pid            = done_ok ? res_word[WORD_W-1 -: PID_BITS] : '0;
        res_info.job       = done_ok ? res_word[STATE_W +: JOB_W] : '0;
        res_info.job_state = done_ok ? res_word[STATE_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FSM_IDLE;
            rd_busy_reg  <= 1'b0;
            dv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            inval_reg    <= 1'b0;
            next_job_reg <= JOB_ONE;
        end else begin
            fsm_reg      <= fsm_next;
            rd_busy_reg  <= rd_busy_next;
            dv_reg       <= mem_rd_en;
            found_reg    <= found_next;
            inval_reg    <= inval_next;
            next_job_reg <= next_job_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        pid_reg     <= pid_next;
        job_reg     <= job_next;
        nst_reg     <= nst_next;
        rd_addr_reg <= rd_addr_next;
        didx_reg    <= rd_addr_reg;
        slot_reg    <= slot_next;
        cap_reg     <= cap_next;
        max_reg     <= max_next;
    end

endmodule

// ----- design/jte_checker.sv -----
`include "job_table_engine_unit_assert.svh"

module jte_checker #(
    parameter int PID_BITS = jte_pkg::PID_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [jte_pkg::STATUS_W-1:0] m_status,
    input logic [PID_BITS-1:0]          m_pid_out,
    input logic [jte_pkg::JOB_W-1:0]    m_job_out,
    input logic [jte_pkg::STATE_W-1:0]  m_state_out
);

    // Hold a stalled result.
    `JTE_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_pid_out) && $stable(m_job_out) && $stable(m_state_out), "stalled result changed")

    // One request in flight: busy right after an accept.
    `JTE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "request accepted while busy")

    `JTE_ASSERT_NOW(a_fail_zero, m_valid && m_status != jte_pkg::STS_OK, m_pid_out == '0 && m_job_out == '0 && m_state_out == '0, "failed request carries entry data")

    // Any entry reported as ok is occupied and numbered.
    `JTE_ASSERT_NOW(a_ok_entry, m_valid && m_status == jte_pkg::STS_OK, m_pid_out != '0 && m_job_out != '0, "ok result names an empty slot")

endmodule

bind job_table_engine_unit jte_checker #(
    .PID_BITS (PID_BITS)
) u_jte_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_pid_out   (m_pid_out),
    .m_job_out   (m_job_out),
    .m_state_out (m_state_out)
);

// ----- bench/job_table_checker.sv -----
module job_table_checker #(
    parameter int TABLE_ENTRIES = jte_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_JOB_ID    = jte_pkg::MAX_JOB_ID_DEF,
    parameter int PID_BITS      = jte_pkg::PID_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [jte_pkg::ACTION_W-1:0] s_action,
    input  logic [PID_BITS-1:0]          s_pid_value,
    input  logic [jte_pkg::JOB_W-1:0]    s_job_number,
    input  logic [jte_pkg::STATE_W-1:0]  s_new_state,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [jte_pkg::STATUS_W-1:0] m_status,
    input  logic [PID_BITS-1:0]          m_pid_out,
    input  logic [jte_pkg::JOB_W-1:0]    m_job_out,
    input  logic [jte_pkg::STATE_W-1:0]  m_state_out,
    output int                           error_count,
    output int                           replies_due
);
    import jte_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_BITS-1:0] pid;
        logic [JOB_W-1:0]    job;
        logic [STATE_W-1:0]  run_state;
    } job_reply_t;

    logic [PID_BITS-1:0] slot_pid   [TABLE_ENTRIES];
    logic [JOB_W-1:0]    slot_job   [TABLE_ENTRIES];
    logic [STATE_W-1:0]  slot_state [TABLE_ENTRIES];
    logic [JOB_W-1:0]    next_job;

    job_reply_t awaited_replies [$];
    job_reply_t oldest_reply;

    function automatic int slot_with_pid(input logic [PID_BITS-1:0] pid);
        int hit;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && slot_pid[i] == pid)
                hit = i;
        return hit;
    endfunction

    function automatic job_reply_t slot_reply(input logic [STATUS_W-1:0] code, input int slot);
        job_reply_t r;
        r = '0;
        r.status = code;
        if (slot >= 0) begin
            r.pid       = slot_pid[slot];
            r.job       = slot_job[slot];
            r.run_state = slot_state[slot];
        end
        return r;
    endfunction

    // Update the job table for one request and return the reply it should produce.
    function automatic job_reply_t apply_request(
        input logic [ACTION_W-1:0] act,
        input logic [PID_BITS-1:0] pid,
        input logic [JOB_W-1:0]    job,
        input logic [STATE_W-1:0]  new_state
    );
        job_reply_t          reply;
        int                  slot;
        bit                  searched;
        logic [JOB_W-1:0]    top;
        reply    = slot_reply(STS_INVALID, -1);
        slot     = -1;
        searched = 1'b0;
        case (act)
            ACT_ADD: begin
                if (pid != '0) begin
                    slot = slot_with_pid('0);
                    if (slot < 0) begin
                        reply = slot_reply(STS_FULL, -1);
                    end else begin
                        slot_pid[slot]   = pid;
                        slot_state[slot] = new_state;
                        slot_job[slot]   = next_job;
                        next_job = (int'(next_job) + 1 > MAX_JOB_ID) ? JOB_W'(1)
                                                                     : next_job + 1'b1;
                        reply = slot_reply(STS_OK, slot);
                    end
                end
            end
            ACT_DEL_PID: begin
                if (pid != '0) begin
                    slot = slot_with_pid(pid);
                    if (slot < 0) begin
                        reply = slot_reply(STS_NOT_FOUND, -1);
                    end else begin
                        // report the entry as it was, then free it
                        reply = slot_reply(STS_OK, slot);
                        slot_pid[slot]   = '0;
                        slot_job[slot]   = '0;
                        slot_state[slot] = '0;
                        top = '0;
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                            if (slot_job[i] > top)
                                top = slot_job[i];
                        next_job = (int'(top) + 1 > MAX_JOB_ID) ? JOB_W'(1) : top + 1'b1;
                    end
                end
            end
            ACT_FIND_PID, ACT_SET_PID: begin
                if (pid != '0) begin
                    searched = 1'b1;
                    slot = slot_with_pid(pid);
                end
            end
            ACT_FIND_JOB, ACT_SET_JOB: begin
                if (job != '0) begin
                    searched = 1'b1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot < 0 && slot_job[i] == job)
                            slot = i;
                end
            end
            ACT_FIND_FG: begin
                searched = 1'b1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot < 0 && slot_state[i] == JOB_ST_FG)
                        slot = i;
            end
            default: ;
        endcase
        if (searched) begin
            if (slot < 0) begin
                reply = slot_reply(STS_NOT_FOUND, -1);
            end else begin
                if (act == ACT_SET_JOB || act == ACT_SET_PID)
                    slot_state[slot] = new_state;
                reply = slot_reply(STS_OK, slot);
            end
        end
        return reply;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_pid[i]   = '0;
                slot_job[i]   = '0;
                slot_state[i] = '0;
            end
            next_job = JOB_W'(1);
            awaited_replies.delete();
        end else begin
            // retire the reply before predicting a request taken on the same edge
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply with no request outstanding: status %0d pid %0d job %0d",
                           m_status, m_pid_out, m_job_out);
                    error_count++;
                end else begin
                    oldest_reply = awaited_replies.pop_front();
                    check_field("status", 32'(oldest_reply.status), 32'(m_status));
                    check_field("pid_out", 32'(oldest_reply.pid), 32'(m_pid_out));
                    check_field("job_out", 32'(oldest_reply.job), 32'(m_job_out));
                    check_field("state_out", 32'(oldest_reply.run_state), 32'(m_state_out));
                end
            end
            if (s_valid && s_ready)
                awaited_replies.push_back(apply_request(s_action, s_pid_value,
                                                        s_job_number, s_new_state));
        end
        replies_due = awaited_replies.size();
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import jte_pkg::*;

    localparam int PID_W        = PID_BITS_DEF;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 180;
    localparam int POOL_SIZE    = 20;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [ACTION_W-1:0] ACT_UNUSED   = 3'd7;
    localparam logic [STATE_W-1:0]  JOB_ST_NONE  = 2'd0;
    localparam logic [STATE_W-1:0]  JOB_ST_BG    = 2'd2;
    localparam logic [STATE_W-1:0]  JOB_ST_STOP  = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action;
    logic [PID_W-1:0]    s_pid_value;
    logic [JOB_W-1:0]    s_job_number;
    logic [STATE_W-1:0]  s_new_state;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [PID_W-1:0]    m_pid_out;
    logic [JOB_W-1:0]    m_job_out;
    logic [STATE_W-1:0]  m_state_out;

    int               error_count;
    int               replies_due;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_off_len;
    int               job_hint;
    int               cycle_count;
    logic [PID_W-1:0] pid_pool [POOL_SIZE];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    job_table_engine_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_pid_value  (s_pid_value),
        .s_job_number (s_job_number),
        .s_new_state  (s_new_state),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_pid_out    (m_pid_out),
        .m_job_out    (m_job_out),
        .m_state_out  (m_state_out)
    );

    job_table_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_pid_value  (s_pid_value),
        .s_job_number (s_job_number),
        .s_new_state  (s_new_state),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_pid_out    (m_pid_out),
        .m_job_out    (m_job_out),
        .m_state_out  (m_state_out),
        .error_count  (error_count),
        .replies_due  (replies_due)
    );

    // Offer one request and return once it has been taken.
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [PID_W-1:0] pid,
                                input logic [JOB_W-1:0] job, input logic [STATE_W-1:0] st);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_pid_value  <= pid;
        s_job_number <= job;
        s_new_state  <= st;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (act == ACT_ADD)
            job_hint++;
    endtask

    task automatic send_random_request(input int add_pct);
        int                  pick;
        int                  lo;
        logic [ACTION_W-1:0] act;
        logic [PID_W-1:0]    pid;
        logic [JOB_W-1:0]    job;
        pick = $urandom_range(99);
        if (pick < add_pct) begin
            act = ACT_ADD;
        end else begin
            pick = $urandom_range(99);
            act = (pick < 20) ? ACT_DEL_PID  :
                  (pick < 36) ? ACT_FIND_PID :
                  (pick < 52) ? ACT_FIND_JOB :
                  (pick < 68) ? ACT_SET_JOB  :
                  (pick < 84) ? ACT_SET_PID  :
                  (pick < 96) ? ACT_FIND_FG  : ACT_UNUSED;
        end
        pick = $urandom_range(99);
        if (pick < 85)
            pid = pid_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 96)
            pid = PID_W'($urandom());
        else
            pid = '0;
        // aim job numbers near the ones handed out lately
        pick = $urandom_range(99);
        lo = (job_hint > 24) ? job_hint - 24 : 1;
        if (pick < 78)
            job = JOB_W'($urandom_range(job_hint + 1, lo));
        else if (pick < 94)
            job = JOB_W'($urandom());
        else
            job = '0;
        send_request(act, pid, job, STATE_W'($urandom_range(3)));
    endtask

    // Drop valid and hold until every outstanding reply has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (replies_due != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_len > 0) begin
                hold_left = hold_off_len;
                hold_off_len = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_ADD;
        s_pid_value    = '0;
        s_job_number   = '0;
        s_new_state    = JOB_ST_NONE;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_len   = 0;
        job_hint       = 0;
        pid_pool[0] = '1;
        pid_pool[1] = PID_W'(1);
        for (int i = 2; i < POOL_SIZE; i++)
            pid_pool[i] = (i < 8) ? PID_W'(i) : PID_W'($urandom_range(4194303, 1));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(ACT_FIND_FG, '0, '0, JOB_ST_NONE);        // empty table
        send_request(ACT_ADD, '0, '0, JOB_ST_FG);              // zero pid rejected
        send_request(ACT_ADD, '1, '1, JOB_ST_FG);
        send_request(ACT_ADD, PID_W'(1), '0, JOB_ST_NONE);     // state zero still occupies
        send_request(ACT_ADD, '1, '0, JOB_ST_STOP);            // duplicate pid
        send_request(ACT_FIND_PID, '1, '0, JOB_ST_NONE);
        send_request(ACT_FIND_JOB, '1, '0, JOB_ST_NONE);       // zero job rejected
        send_request(ACT_FIND_JOB, '0, JOB_W'(MAX_JOB_ID_DEF), JOB_ST_NONE);
        send_request(ACT_FIND_JOB, '0, '1, JOB_ST_NONE);       // beyond the last job number
        send_request(ACT_SET_JOB, '0, JOB_W'(3), JOB_ST_FG);
        send_request(ACT_SET_PID, PID_W'(1), '0, JOB_ST_BG);
        send_request(ACT_FIND_FG, '0, '0, JOB_ST_NONE);
        send_request(ACT_SET_PID, '0, JOB_W'(2), JOB_ST_BG);
        send_request(ACT_DEL_PID, '1, '0, JOB_ST_NONE);        // lowest duplicate goes
        send_request(ACT_DEL_PID, PID_W'(12345), '0, JOB_ST_NONE);
        send_request(ACT_UNUSED, '1, '1, JOB_ST_STOP);
        // fill every free slot, then one more
        for (int i = 0; i < 15; i++)
            send_request(ACT_ADD, PID_W'(100 + i), '0, STATE_W'(i));
        send_request(ACT_DEL_PID, PID_W'(113), '0, JOB_ST_NONE);

        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 0 && n == 60)
                    hold_off_len = HOLD_CYCLES;
                send_random_request((phase % 2 == 0) ? 40 : 22);
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
